/* design/sdsf_pkg.sv */
package sdsf_pkg;

	// Number of segment bytes on the result side and width of the value field.
	localparam int SEG_FIELDS = 6;
	localparam int VALUE_W = 24;
	localparam int TIME_W = 7;

	// Special segment patterns.
	localparam logic [7:0] SEG_DASH = 8'h40;
	localparam logic [7:0] SEG_DOT = 8'h80;
	localparam logic [7:0] SEG_BLANK = 8'h00;

	// Largest value of one time field.
	localparam logic [TIME_W-1:0] TIME_MAX = 7'd99;

	typedef enum logic [1:0] {
		CMD_VALUE = 2'd0,
		CMD_HM    = 2'd1,
		CMD_HMS   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef logic [SEG_FIELDS-1:0][3:0] bcd_vec_t;
	typedef logic [SEG_FIELDS-1:0][7:0] seg_vec_t;

	// Request details that the formatter needs once the digits are ready.
	typedef struct packed {
		cmd_t              cmd;
		logic [2:0]        n;
		logic              neg;
		logic              fits;
		logic              colon;
		logic              lead;
		logic [TIME_W-1:0] hours;
		logic [TIME_W-1:0] minutes;
		logic [TIME_W-1:0] seconds;
	} ctrl_t;

	// Segment pattern of one decimal digit.
	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		unique case (d)
			4'd0: g = 8'h3F;
			4'd1: g = 8'h06;
			4'd2: g = 8'h5B;
			4'd3: g = 8'h4F;
			4'd4: g = 8'h66;
			4'd5: g = 8'h6D;
			4'd6: g = 8'h7D;
			4'd7: g = 8'h27;
			4'd8: g = 8'h7F;
			4'd9: g = 8'h6F;
			default: g = SEG_BLANK;
		endcase
		return g;
	endfunction

	// Powers of ten up to one million.
	function automatic logic [VALUE_W-1:0] pow10(input logic [2:0] e);
		logic [VALUE_W-1:0] p;
		unique case (e)
			3'd0: p = 24'd1;
			3'd1: p = 24'd10;
			3'd2: p = 24'd100;
			3'd3: p = 24'd1000;
			3'd4: p = 24'd10000;
			3'd5: p = 24'd100000;
			3'd6: p = 24'd1000000;
			default: p = 24'd0;
		endcase
		return p;
	endfunction

	// Tens digit of a value up to 99, by multiplying with the reciprocal 205/2048.
	function automatic logic [3:0] tens(input logic [TIME_W-1:0] x);
		logic [14:0] p;
		p = 15'(x) * 15'd205;
		return p[14:11];
	endfunction

	// Units digit of a value up to 99.
	function automatic logic [3:0] units(input logic [TIME_W-1:0] x);
		logic [TIME_W-1:0] r;
		r = x - 7'(tens(x)) * 7'd10;
		return r[3:0];
	endfunction

endpackage

/* design/signed_decimal_seven_segment_formatter.sv */
// Formats a signed value or a time of day into the segment bytes of a seven-segment
// display of up to six digits. A request is taken when start is high and busy is low;
// the result appears on seg0..seg5, used_digits and overflow for exactly one cycle with
// done high, and the receiver must take it in that cycle since it cannot stall the block.
// For a value request the 24 bits of the magnitude are shifted through a row of BCD digit
// cells one bit per cycle, after a range check state and before a layout state. For time
// requests and the unused command the range check state is followed directly by the layout
// state. A new request can be accepted in the done cycle.
// digit_count is written through cfg_valid/cfg_ready/cfg_data; the user must write it only
// while the block is idle, since the block itself does not enforce this.
module signed_decimal_seven_segment_formatter #(
	parameter int MAX_DIGITS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic [1:0]         cmd,
	input  logic signed [23:0] value,
	input  logic [6:0]         hours,
	input  logic [6:0]         minutes,
	input  logic [6:0]         seconds,
	input  logic               colon_on,
	input  logic               leading_zero,
	output logic [7:0]         seg0,
	output logic [7:0]         seg1,
	output logic [7:0]         seg2,
	output logic [7:0]         seg3,
	output logic [7:0]         seg4,
	output logic [7:0]         seg5,
	output logic [2:0]         used_digits,
	output logic               overflow,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_data
);

	localparam int LIM = (MAX_DIGITS < sdsf_pkg::SEG_FIELDS) ? MAX_DIGITS
		: sdsf_pkg::SEG_FIELDS;
	localparam int CNT_W = $clog2(sdsf_pkg::VALUE_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SHIFT,
		ST_FORMAT
	} state_t;

	state_t                         state_q;
	logic                           done_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [2:0]                     digit_count_q;
	logic [2:0]                     n_eff;
	logic                           accept;
	sdsf_pkg::ctrl_t                ctrl_q;
	logic [sdsf_pkg::VALUE_W-1:0]   mag_q;
	logic [sdsf_pkg::VALUE_W-1:0]   bound;
	sdsf_pkg::seg_vec_t             seg_q;
	logic [2:0]                     used_q;
	logic                           ovf_q;
	logic [LIM-1:0][3:0]            cell_digit;
	logic [LIM-1:0]                 cell_carry;
	sdsf_pkg::bcd_vec_t             digits;
	sdsf_pkg::seg_vec_t             seg_next;
	logic [2:0]                     used_next;
	logic                           ovf_next;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= 3'd4;
		end else if (cfg_valid && cfg_ready) begin
			digit_count_q <= cfg_data;
		end
	end

	// Effective digit count: zero counts as one, and it never exceeds the display.
	always_comb begin
		priority if (digit_count_q == 3'd0) begin
			n_eff = 3'd1;
		end else if (int'(digit_count_q) > LIM) begin
			n_eff = 3'(LIM);
		end else begin
			n_eff = digit_count_q;
		end
	end

	// Sequencer: range check, one shift per value bit for value requests, then layout into the result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
			seg_q <= '0;
			used_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					cnt_q <= '0;
					state_q <= (ctrl_q.cmd == sdsf_pkg::CMD_VALUE) ? ST_SHIFT : ST_FORMAT;
				end
				ST_SHIFT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(sdsf_pkg::VALUE_W - 1)) begin
						state_q <= ST_FORMAT;
					end
				end
				ST_FORMAT: begin
					seg_q <= seg_next;
					used_q <= used_next;
					ovf_q <= ovf_next;
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Upper bound for the magnitude: 10^(n-1) when negative, 10^n otherwise.
	assign bound = sdsf_pkg::pow10(ctrl_q.neg ? ctrl_q.n - 3'd1 : ctrl_q.n);

	// Request fields and magnitude shift register.
	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_q.cmd <= sdsf_pkg::cmd_t'(cmd);
			ctrl_q.n <= n_eff;
			ctrl_q.neg <= value[23];
			ctrl_q.fits <= 1'b0;
			ctrl_q.colon <= colon_on;
			ctrl_q.lead <= leading_zero;
			ctrl_q.hours <= (hours > sdsf_pkg::TIME_MAX) ? sdsf_pkg::TIME_MAX : hours;
			ctrl_q.minutes <= (minutes > sdsf_pkg::TIME_MAX) ? sdsf_pkg::TIME_MAX : minutes;
			ctrl_q.seconds <= (seconds > sdsf_pkg::TIME_MAX) ? sdsf_pkg::TIME_MAX : seconds;
			mag_q <= value[23] ? 24'(-value) : 24'(value);
		end else if (state_q == ST_CHECK) begin
			ctrl_q.fits <= (mag_q < bound);
		end else if (state_q == ST_SHIFT) begin
			mag_q <= {mag_q[sdsf_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	// Row of BCD digit cells, least significant digit first.
	for (genvar i = 0; i < LIM; i++) begin : g_cell
		sdsf_bcd_cell u_cell (
			.clk    (clk),
			.clear  (state_q == ST_CHECK),
			.shift  (state_q == ST_SHIFT),
			.bit_in ((i == 0) ? mag_q[sdsf_pkg::VALUE_W-1] : cell_carry[(i == 0) ? 0 : i-1]),
			.digit  (cell_digit[i]),
			.carry  (cell_carry[i])
		);
	end

	// Digits beyond the row read as zero.
	always_comb begin
		digits = '0;
		for (int i = 0; i < LIM; i++) begin
			digits[i] = cell_digit[i];
		end
	end

	sdsf_seg_build u_build (
		.ctrl   (ctrl_q),
		.digits (digits),
		.seg    (seg_next),
		.used   (used_next),
		.ovf    (ovf_next)
	);

	assign done = done_q;
	assign seg0 = seg_q[0];
	assign seg1 = seg_q[1];
	assign seg2 = seg_q[2];
	assign seg3 = seg_q[3];
	assign seg4 = seg_q[4];
	assign seg5 = seg_q[5];
	assign used_digits = used_q;
	assign overflow = ovf_q;

	// An accepted request always makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// The result strobe lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// An overflow result shows a dash in the leftmost digit and uses at least one digit.
	a_ovf_dash: assert property (@(posedge clk) disable iff (!arst_n)
		done && overflow |-> seg0 == sdsf_pkg::SEG_DASH && used_digits != 3'd0)
		else $error("overflow result without dashes");

endmodule

/* design/sdsf_bcd_cell.sv */
module sdsf_bcd_cell (
	input  logic       clk,
	input  logic       clear,
	input  logic       shift,
	input  logic       bit_in,
	output logic [3:0] digit,
	output logic       carry
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Add three when the digit is five or more, so the shift stays decimal.
	assign adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry = adj[3];
	assign digit = digit_q;

	// Shift one bit in from the lower neighbor each cycle that shift is high.
	always_ff @(posedge clk) begin
		if (clear) begin
			digit_q <= 4'd0;
		end else if (shift) begin
			digit_q <= {adj[2:0], bit_in};
		end
	end

endmodule

/* design/sdsf_seg_build.sv */
module sdsf_seg_build (
	input  sdsf_pkg::ctrl_t    ctrl,
	input  sdsf_pkg::bcd_vec_t digits,
	output sdsf_pkg::seg_vec_t seg,
	output logic [2:0]         used,
	output logic               ovf
);

	logic [2:0] sig;
	logic [2:0] k;
	logic [3:0] ht;

	// Count of significant digits of the converted magnitude, at least one.
	always_comb begin
		sig = 3'd1;
		for (int i = 0; i < sdsf_pkg::SEG_FIELDS; i++) begin
			if (digits[i] != 4'd0) begin
				sig = 3'(i + 1);
			end
		end
	end

	assign ht = sdsf_pkg::tens(ctrl.hours);

	// Lay out the segment bytes for the requested mode.
	always_comb begin
		seg = '0;
		used = ctrl.n;
		ovf = 1'b0;
		k = 3'd0;
		unique case (ctrl.cmd)
			sdsf_pkg::CMD_VALUE: begin
				if (!ctrl.fits) begin
					ovf = 1'b1;
					for (int p = 0; p < sdsf_pkg::SEG_FIELDS; p++) begin
						if (p < int'(ctrl.n)) begin
							seg[p] = sdsf_pkg::SEG_DASH;
						end
					end
				end else begin
					for (int p = 0; p < sdsf_pkg::SEG_FIELDS; p++) begin
						k = 3'(int'(ctrl.n) - 1 - p);
						if (p < int'(ctrl.n)) begin
							if (k < sig) begin
								seg[p] = sdsf_pkg::glyph(digits[k]);
							end else if (ctrl.neg && k == sig) begin
								seg[p] = sdsf_pkg::SEG_DASH;
							end
						end
					end
				end
			end
			sdsf_pkg::CMD_HM, sdsf_pkg::CMD_HMS: begin
				seg[0] = (ht != 4'd0 || ctrl.lead) ? sdsf_pkg::glyph(ht) : sdsf_pkg::SEG_BLANK;
				seg[1] = sdsf_pkg::glyph(sdsf_pkg::units(ctrl.hours));
				seg[2] = sdsf_pkg::glyph(sdsf_pkg::tens(ctrl.minutes));
				seg[3] = sdsf_pkg::glyph(sdsf_pkg::units(ctrl.minutes));
				if (ctrl.cmd == sdsf_pkg::CMD_HM) begin
					if (ctrl.colon) begin
						seg[1] = seg[1] | sdsf_pkg::SEG_DOT;
					end
					used = 3'd4;
				end else begin
					seg[2] = seg[2] | sdsf_pkg::SEG_DOT;
					seg[4] = sdsf_pkg::glyph(sdsf_pkg::tens(ctrl.seconds)) | sdsf_pkg::SEG_DOT;
					seg[5] = sdsf_pkg::glyph(sdsf_pkg::units(ctrl.seconds));
					used = 3'd6;
				end
			end
			default: begin
				seg = '0;
			end
		endcase
	end

endmodule

/* test/signed_decimal_seven_segment_formatter_test.sv */
`timescale 1ns / 100ps

module signed_decimal_seven_segment_formatter_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PER_SETTING = 160;
	localparam int MAX_REPORTS = 10;

	// Segment patterns of the decimal digits, bit 0 is segment a.
	localparam logic [7:0] DIGIT_SEGS [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27, 8'h7F, 8'h6F
	};

	typedef struct {
		sdsf_pkg::cmd_t     cmd;
		logic signed [23:0] value;
		logic [6:0]         hours;
		logic [6:0]         minutes;
		logic [6:0]         seconds;
		logic               colon_on;
		logic               leading_zero;
	} request_t;

	typedef struct {
		sdsf_pkg::seg_vec_t segs;
		logic [2:0]         used;
		logic               ovf;
	} display_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	logic [1:0] cmd = '0;
	logic signed [23:0] value = '0;
	logic [6:0] hours = '0;
	logic [6:0] minutes = '0;
	logic [6:0] seconds = '0;
	logic colon_on = 1'b0;
	logic leading_zero = 1'b0;
	logic [7:0] seg0, seg1, seg2, seg3, seg4, seg5;
	logic [2:0] used_digits;
	logic overflow;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_data = '0;

	request_t pending_requests[$];
	display_t expected_displays[$];
	request_t in_flight;
	logic [2:0] digit_count_model = 3'd4;
	int idle_pct = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	signed_decimal_seven_segment_formatter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.cmd(cmd),
		.value(value),
		.hours(hours),
		.minutes(minutes),
		.seconds(seconds),
		.colon_on(colon_on),
		.leading_zero(leading_zero),
		.seg0(seg0),
		.seg1(seg1),
		.seg2(seg2),
		.seg3(seg3),
		.seg4(seg4),
		.seg5(seg5),
		.used_digits(used_digits),
		.overflow(overflow),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Time fields above 99 are shown as 99.
	function automatic int sat99(logic [6:0] x);
		return (x > 7'd99) ? 99 : int'(x);
	endfunction

	// Computes the whole display for one request under the given digit count.
	function automatic display_t format_display(request_t r, logic [2:0] count);
		display_t d;
		int n;
		int mag;
		int limit;
		int pos;
		int h;
		int m;
		int s;
		logic neg;
		d.segs = '0;
		d.ovf = 1'b0;
		n = int'(count);
		if (n < 1) n = 1;
		if (n > 6) n = 6;
		d.used = 3'(n);
		unique case (r.cmd)
			sdsf_pkg::CMD_VALUE: begin
				neg = r.value[23];
				mag = neg ? -int'(r.value) : int'(r.value);
				limit = 1;
				for (int i = 0; i < n; i++) limit *= 10;
				// Negative values give up one digit to the sign.
				if (neg) limit /= 10;
				if (mag > limit - 1) begin
					d.ovf = 1'b1;
					for (int i = 0; i < n; i++) d.segs[i] = sdsf_pkg::SEG_DASH;
				end else if (mag == 0) begin
					d.segs[n-1] = DIGIT_SEGS[0];
				end else begin
					pos = n;
					while (pos > 0 && mag > 0) begin
						pos--;
						d.segs[pos] = DIGIT_SEGS[mag % 10];
						mag /= 10;
					end
					if (neg && pos > 0) d.segs[pos-1] = sdsf_pkg::SEG_DASH;
				end
			end
			sdsf_pkg::CMD_HM, sdsf_pkg::CMD_HMS: begin
				h = sat99(r.hours);
				m = sat99(r.minutes);
				s = sat99(r.seconds);
				d.segs[0] = (h >= 10 || r.leading_zero) ? DIGIT_SEGS[h / 10]
					: sdsf_pkg::SEG_BLANK;
				d.segs[1] = DIGIT_SEGS[h % 10];
				d.segs[2] = DIGIT_SEGS[m / 10];
				d.segs[3] = DIGIT_SEGS[m % 10];
				if (r.cmd == sdsf_pkg::CMD_HM) begin
					if (r.colon_on) d.segs[1] |= sdsf_pkg::SEG_DOT;
					d.used = 3'd4;
				end else begin
					d.segs[2] |= sdsf_pkg::SEG_DOT;
					d.segs[4] = DIGIT_SEGS[s / 10] | sdsf_pkg::SEG_DOT;
					d.segs[5] = DIGIT_SEGS[s % 10];
					d.used = 3'd6;
				end
			end
			default: begin
			end
		endcase
		return d;
	endfunction

	function automatic request_t make_request(sdsf_pkg::cmd_t c, int v, int h, int m, int s,
			int colon, int lead);
		request_t r;
		r.cmd = c;
		r.value = 24'(v);
		r.hours = 7'(h);
		r.minutes = 7'(m);
		r.seconds = 7'(s);
		r.colon_on = 1'(colon);
		r.leading_zero = 1'(lead);
		return r;
	endfunction

	// Random request: mostly values close to the powers of ten, where the range
	// limits and the sign placement change, plus times with some saturated fields.
	function automatic request_t random_request();
		request_t r;
		int sel;
		int mag;
		int base;
		r.value = 24'($urandom);
		r.hours = 7'($urandom);
		r.minutes = 7'($urandom);
		r.seconds = 7'($urandom);
		r.colon_on = 1'($urandom);
		r.leading_zero = 1'($urandom);
		sel = $urandom_range(99);
		if (sel < 55) r.cmd = sdsf_pkg::CMD_VALUE;
		else if (sel < 75) r.cmd = sdsf_pkg::CMD_HM;
		else if (sel < 95) r.cmd = sdsf_pkg::CMD_HMS;
		else r.cmd = sdsf_pkg::CMD_NONE;
		if (r.cmd == sdsf_pkg::CMD_VALUE && $urandom_range(99) < 65) begin
			base = 1;
			repeat ($urandom_range(6)) base *= 10;
			mag = base - 2 + $urandom_range(3);
			if ($urandom_range(3) == 0) mag = $urandom_range(base);
			if (mag < 0) mag = 0;
			r.value = $urandom_range(1) ? 24'(-mag) : 24'(mag);
		end
		if (r.cmd != sdsf_pkg::CMD_VALUE && $urandom_range(99) < 85) begin
			r.hours = 7'($urandom_range(99));
			r.minutes = 7'($urandom_range(99));
			r.seconds = 7'($urandom_range(99));
		end
		return r;
	endfunction

	task automatic report_failure(string what, int expected_val, int actual_val);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s expected 0x%0h, got 0x%0h", $realtime, what,
				expected_val, actual_val);
	endtask

	// Clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Request driver: loads the next pending request when the port is free.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_displays.push_back(format_display(in_flight, digit_count_model));
			if (!start || !busy) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
					in_flight = pending_requests.pop_front();
					cmd <= in_flight.cmd;
					value <= in_flight.value;
					hours <= in_flight.hours;
					minutes <= in_flight.minutes;
					seconds <= in_flight.seconds;
					colon_on <= in_flight.colon_on;
					leading_zero <= in_flight.leading_zero;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Result monitor: each done cycle is one transfer, checked against the oldest expectation.
	always @(posedge clk) begin
		display_t exp_display;
		sdsf_pkg::seg_vec_t seen;
		if (arst_n && done) begin
			seen = {seg5, seg4, seg3, seg2, seg1, seg0};
			if (expected_displays.size() == 0) begin
				report_failure("unexpected result, seg0..seg5", 0, int'(seen));
			end else begin
				exp_display = expected_displays.pop_front();
				for (int i = 0; i < sdsf_pkg::SEG_FIELDS; i++)
					if (seen[i] !== exp_display.segs[i])
						report_failure($sformatf("seg%0d", i), int'(exp_display.segs[i]),
							int'(seen[i]));
				if (used_digits !== exp_display.used)
					report_failure("used_digits", int'(exp_display.used), int'(used_digits));
				if (overflow !== exp_display.ovf)
					report_failure("overflow", int'(exp_display.ovf), int'(overflow));
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Waits until every request has been taken and every result has come back.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_requests.size() > 0 || start || expected_displays.size() > 0);
	endtask

	task automatic write_digit_count(logic [2:0] count);
		cfg_data <= count;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		digit_count_model = count;
	endtask

	// Sequencer: directed requests, then random ones under each digit count setting.
	initial begin
		logic [2:0] settings [9] = '{3'd4, 3'd1, 3'd6, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd4};
		int idle_by_phase [4] = '{0, 71, 0, 29};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset digit count of four.
		pending_requests.push_back(make_request(sdsf_pkg::CMD_VALUE, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_VALUE, 1, 127, 127, 127, 1, 1));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_VALUE, -1, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_VALUE, -7, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_VALUE, 42, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_VALUE, 9999, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_VALUE, 10000, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_VALUE, -999, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_VALUE, -1000, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_VALUE, 8388607, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_VALUE, -8388608, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_HM, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_HM, 0, 0, 0, 0, 1, 1));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_HM, 0, 5, 7, 0, 1, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_HM, 0, 10, 0, 0, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_HM, 0, 99, 59, 0, 1, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_HM, 0, 127, 100, 127, 0, 1));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_HMS, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_HMS, 0, 9, 8, 7, 1, 1));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_HMS, 0, 23, 59, 59, 1, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_HMS, 0, 127, 127, 100, 0, 0));
		pending_requests.push_back(make_request(sdsf_pkg::CMD_NONE, -8388608, 127, 127, 127,
			1, 1));
		wait_drained();

		// Random part under each setting, the extremes and out-of-range counts among them.
		foreach (settings[p]) begin
			if (p > 0) begin
				repeat (4) @(posedge clk);
				write_digit_count(settings[p]);
			end
			idle_pct = idle_by_phase[p % 4];
			repeat (RANDOM_PER_SETTING) pending_requests.push_back(random_request());
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && expected_displays.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
